>>> hw/rtl/szt_pkg.sv
// shared types, register map and constants of the steering zero-torque calibration
package szt_pkg;

  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  // register map: byte address is 4 * index
  typedef enum logic [2:0] {
    REG_TIMEOUT_MS  = 3'd0,
    REG_DRIVE_STOP  = 3'd1,
    REG_RETURN_IDLE = 3'd2,
    REG_RETURN_GAIN = 3'd3,
    REG_FULL_EFFORT = 3'd4,
    REG_INIT_ZT     = 3'd5
  } reg_idx_e;

  // calibration sequence phases
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_CCW_FIRST = 3'd1,
    PH_RETURN_A  = 3'd2,
    PH_CW        = 3'd3,
    PH_RETURN_B  = 3'd4,
    PH_CCW_LAST  = 3'd5,
    PH_ADJUST    = 3'd6
  } phase_e;

  typedef struct packed {
    logic        [15:0] timeout_ms;
    logic        [14:0] drive_stop_angle;
    logic        [14:0] return_idle_angle;
    logic        [15:0] return_gain;
    logic        [14:0] full_effort;
    logic signed [15:0] initial_zero_torque;
  } cfg_t;

  // reload of the zero torque offset on a write of its initial value
  typedef struct packed {
    logic               load;
    logic signed [15:0] value;
  } zt_load_t;

  localparam logic        [15:0] RstTimeoutMs  = 16'd5000;
  localparam logic        [14:0] RstDriveStop  = 15'd1065;
  localparam logic        [14:0] RstReturnIdle = 15'd0;
  localparam logic        [15:0] RstReturnGain = 16'd2000;
  localparam logic        [14:0] RstFullEffort = 15'd100;
  localparam logic signed [15:0] RstInitZt     = -16'sd30;

  // effort saturation
  localparam logic signed [15:0] EffortMax = 16'sd32767;
  localparam logic signed [15:0] EffortMin = -16'sd32767;

  // divide by ten: (x * Recip10) >> Recip10Shift is exact for x < 2^Div10InW
  localparam int unsigned      Div10InW     = 21;
  localparam int unsigned      Recip10Shift = 24;
  localparam logic [20:0]      Recip10      = 21'd1677722;
  localparam int unsigned      CorrW        = 18;

  localparam logic signed [15:0] ZtMax = 16'sd32767;
  localparam logic signed [15:0] ZtMin = -16'sd32768;

endpackage

>>> hw/rtl/szt_if.sv
// valid/ready channels for control ticks and calibration results

interface szt_tick_if;
  logic               valid;
  logic               ready;
  logic        [31:0] time_ms;
  logic signed [15:0] wheel_angle;
  logic               start_request;

  modport source (output valid, time_ms, wheel_angle, start_request, input ready);
  modport sink   (input valid, time_ms, wheel_angle, start_request, output ready);
endinterface

interface szt_result_if;
  logic               valid;
  logic               ready;
  logic               busy_res;
  logic               effort_valid;
  logic signed [15:0] rotational_effort;
  logic               done_res;
  logic signed [15:0] zero_torque;

  modport source (output valid, busy_res, effort_valid, rotational_effort, done_res,
                  zero_torque, input ready);
  modport sink   (input valid, busy_res, effort_valid, rotational_effort, done_res,
                  zero_torque, output ready);
endinterface

>>> hw/rtl/szt_apb_regs.sv
// apb configuration registers of the calibration sequencer
module szt_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [szt_pkg::ApbAddrW-1:0] paddr,
  input  logic [szt_pkg::ApbDataW-1:0] pwdata,
  output logic [szt_pkg::ApbDataW-1:0] prdata,
  output logic                         pready,
  output szt_pkg::cfg_t                cfg_o,
  output szt_pkg::zt_load_t            zt_load_o
);
  import szt_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  reg_idx_e   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_TIMEOUT_MS:  cfg_d.timeout_ms          = pwdata[15:0];
        REG_DRIVE_STOP:  cfg_d.drive_stop_angle    = pwdata[14:0];
        REG_RETURN_IDLE: cfg_d.return_idle_angle   = pwdata[14:0];
        REG_RETURN_GAIN: cfg_d.return_gain         = pwdata[15:0];
        REG_FULL_EFFORT: cfg_d.full_effort         = pwdata[14:0];
        REG_INIT_ZT:     cfg_d.initial_zero_torque = $signed(pwdata[15:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ms          <= RstTimeoutMs;
      cfg_q.drive_stop_angle    <= RstDriveStop;
      cfg_q.return_idle_angle   <= RstReturnIdle;
      cfg_q.return_gain         <= RstReturnGain;
      cfg_q.full_effort         <= RstFullEffort;
      cfg_q.initial_zero_torque <= RstInitZt;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // writing the initial offset also reloads the live offset
  assign zt_load_o.load  = wr_en && (idx == REG_INIT_ZT);
  assign zt_load_o.value = $signed(pwdata[15:0]);

  always_comb begin
    case (idx)
      REG_TIMEOUT_MS:  prdata = {16'd0, cfg_q.timeout_ms};
      REG_DRIVE_STOP:  prdata = {17'd0, cfg_q.drive_stop_angle};
      REG_RETURN_IDLE: prdata = {17'd0, cfg_q.return_idle_angle};
      REG_RETURN_GAIN: prdata = {16'd0, cfg_q.return_gain};
      REG_FULL_EFFORT: prdata = {17'd0, cfg_q.full_effort};
      REG_INIT_ZT:     prdata = {{16{cfg_q.initial_zero_torque[15]}},
                                 cfg_q.initial_zero_torque};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/steering_zero_torque_calibration.sv
// top level of the steering zero-torque calibration sequencer
//
// Each word on tick_i is one control tick (timestamp in ms, wheel angle in Q13 radians,
// start request) and yields exactly one word on result_o: busy flag, effort command
// with its valid flag, done pulse and the current zero torque offset. A start request
// launches a run that drives counter-clockwise, returns proportionally, drives
// clockwise, returns again and drives counter-clockwise once more; the clockwise and
// last counter-clockwise drive times set a correction round((cw - ccw) / 10) that is
// added, saturating, to the offset before the run repeats from the first return, and
// a zero correction ends the run with done. The block takes one tick per clock cycle
// back to back while result_o is ready; a result stall holds the tick in the input
// register. A tick passes the input register, then the result register, and the
// sequencer state is read and rewritten for every tick. Configuration goes through the
// apb port at byte address 4*index and should only be written while no tick is in
// flight; writing the initial offset also reloads the live offset at once.
module steering_zero_torque_calibration (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  szt_tick_if.sink                     tick_i,
  szt_result_if.source                 result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [szt_pkg::ApbAddrW-1:0] paddr,
  input  logic [szt_pkg::ApbDataW-1:0] pwdata,
  output logic [szt_pkg::ApbDataW-1:0] prdata,
  output logic                         pready
);
  import szt_pkg::*;

  cfg_t     cfg;
  zt_load_t zt_load;

  szt_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .zt_load_o (zt_load)
  );

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  logic               in_vld_q;
  logic        [31:0] t_q;
  logic signed [15:0] ang_q;
  logic               start_q;
  logic               out_vld_q;
  logic               out_free;
  logic               fire;
  logic               take;

  // result slot is free when empty or being drained this cycle
  assign out_free     = !out_vld_q || result_o.ready;
  assign fire         = in_vld_q && out_free;
  assign tick_i.ready = !in_vld_q || out_free;
  assign take         = tick_i.valid && tick_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (take) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      t_q     <= tick_i.time_ms;
      ang_q   <= tick_i.wheel_angle;
      start_q <= tick_i.start_request;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer state
  // ---------------------------------------------------------------------------
  phase_e             phase_q, phase_d;
  logic               active_q, active_d;
  logic        [31:0] pstart_q, pstart_d;
  logic        [31:0] cw_q, cw_d;
  logic        [31:0] ccw_q, ccw_d;
  logic signed [15:0] zt_q, zt_d;

  // ---------------------------------------------------------------------------
  // per-tick datapath pieces
  // ---------------------------------------------------------------------------
  logic        [15:0] mag;
  logic        [31:0] el_old;
  logic               tmo_old;
  logic               big;
  logic               near_zero;
  logic signed [15:0] full_s;

  assign mag       = ang_q[15] ? 16'(-ang_q) : 16'(ang_q);
  assign el_old    = t_q - pstart_q;
  assign tmo_old   = el_old > {16'd0, cfg.timeout_ms};
  assign big       = mag > {1'b0, cfg.drive_stop_angle};
  assign near_zero = mag < {1'b0, cfg.return_idle_angle};
  assign full_s    = $signed({1'b0, cfg.full_effort});

  // proportional return effort: floor(-(angle * gain) / 2^13), saturated
  logic signed [32:0] ret_prod;
  logic signed [33:0] ret_neg;
  logic signed [20:0] ret_shr;
  logic signed [15:0] ret_eff;

  assign ret_prod = ang_q * $signed({1'b0, cfg.return_gain});
  assign ret_neg  = 34'sd0 - 34'(ret_prod);
  assign ret_shr  = ret_neg[33:13];

  always_comb begin
    if (ret_shr > 21'(EffortMax)) begin
      ret_eff = EffortMax;
    end else if (ret_shr < 21'(EffortMin)) begin
      ret_eff = EffortMin;
    end else begin
      ret_eff = ret_shr[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // tick update: phases run in sequence order, later ones in the same tick
  // after a phase change
  // ---------------------------------------------------------------------------
  logic               fresh;      // phase started on this tick, elapsed is zero
  logic        [31:0] el;
  logic               tmo;
  logic               eff_vld;
  logic signed [15:0] eff;
  logic               done;

  // correction datapath, fed from the values seen at the adjust step
  logic        [31:0] adj_cw;
  logic        [31:0] adj_ccw;
  logic signed [32:0] diff;
  logic        [32:0] diff_abs;
  logic        [33:0] round_in;
  logic        [Div10InW-1:0] div_in;
  logic        [Div10InW+20:0] div_prod;
  logic        [CorrW-1:0]    corr_mag;
  logic signed [19:0] zt_sum;
  logic signed [15:0] zt_sat;

  assign diff     = $signed({1'b0, adj_cw}) - $signed({1'b0, adj_ccw});
  assign diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
  assign round_in = {1'b0, diff_abs} + 34'd5;
  // anything this large saturates the offset anyway
  assign div_in   = (|round_in[33:Div10InW]) ? '1 : round_in[Div10InW-1:0];
  assign div_prod = div_in * Recip10;
  assign corr_mag = div_prod[Recip10Shift +: CorrW];
  assign zt_sum   = diff[32] ? (20'(zt_q) - $signed({2'b00, corr_mag}))
                             : (20'(zt_q) + $signed({2'b00, corr_mag}));

  always_comb begin
    if (zt_sum > 20'(ZtMax)) begin
      zt_sat = ZtMax;
    end else if (zt_sum < 20'(ZtMin)) begin
      zt_sat = ZtMin;
    end else begin
      zt_sat = zt_sum[15:0];
    end
  end

  always_comb begin
    phase_d  = phase_q;
    active_d = active_q || start_q;
    pstart_d = pstart_q;
    cw_d     = cw_q;
    ccw_d    = ccw_q;
    zt_d     = zt_q;
    fresh    = 1'b0;
    eff_vld  = 1'b0;
    eff      = '0;
    done     = 1'b0;
    el       = el_old;
    tmo      = tmo_old;
    adj_cw   = cw_q;
    adj_ccw  = ccw_q;

    if (active_d) begin
      if (phase_d == PH_IDLE) begin
        pstart_d = t_q;
        cw_d     = '0;
        ccw_d    = '0;
        phase_d  = PH_CCW_FIRST;
        fresh    = 1'b1;
      end

      if (phase_d == PH_CCW_FIRST) begin
        el      = fresh ? 32'd0 : el_old;
        tmo     = fresh ? 1'b0 : tmo_old;
        eff     = -full_s;
        eff_vld = 1'b1;
        if (big || tmo) begin
          ccw_d    = el;
          pstart_d = t_q;
          phase_d  = PH_RETURN_A;
          fresh    = 1'b1;
        end
      end

      if (phase_d == PH_RETURN_A || phase_d == PH_RETURN_B) begin
        tmo     = fresh ? 1'b0 : tmo_old;
        eff_vld = 1'b1;
        if (near_zero || tmo) begin
          eff = '0;
          if (tmo) begin
            pstart_d = t_q;
            phase_d  = (phase_d == PH_RETURN_A) ? PH_CW : PH_CCW_LAST;
            fresh    = 1'b1;
          end
        end else begin
          eff = ret_eff;
        end
      end

      if (phase_d == PH_CW) begin
        el      = fresh ? 32'd0 : el_old;
        tmo     = fresh ? 1'b0 : tmo_old;
        eff     = full_s;
        eff_vld = 1'b1;
        if (big || tmo) begin
          cw_d     = el;
          pstart_d = t_q;
          phase_d  = PH_RETURN_B;
          fresh    = 1'b1;
          // second return runs at once with zero elapsed time
          eff      = near_zero ? 16'sd0 : ret_eff;
        end
      end

      if (phase_d == PH_CCW_LAST) begin
        el      = fresh ? 32'd0 : el_old;
        tmo     = fresh ? 1'b0 : tmo_old;
        eff     = -full_s;
        eff_vld = 1'b1;
        if (big || tmo) begin
          ccw_d    = el;
          pstart_d = t_q;
          phase_d  = PH_ADJUST;
          fresh    = 1'b1;
        end
      end

      if (phase_d == PH_ADJUST) begin
        adj_cw  = cw_d;
        adj_ccw = ccw_d;
        if (corr_mag == '0) begin
          phase_d  = PH_IDLE;
          active_d = 1'b0;
          done     = 1'b1;
        end else begin
          zt_d    = zt_sat;
          phase_d = PH_RETURN_A;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      active_q <= 1'b0;
      pstart_q <= '0;
      cw_q     <= '0;
      ccw_q    <= '0;
      zt_q     <= RstInitZt;
    end else if (zt_load.load) begin
      zt_q <= zt_load.value;
    end else if (fire) begin
      phase_q  <= phase_d;
      active_q <= active_d;
      pstart_q <= pstart_d;
      cw_q     <= cw_d;
      ccw_q    <= ccw_d;
      zt_q     <= zt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic               busy_q;
  logic               eff_vld_q;
  logic signed [15:0] eff_q;
  logic               done_q;
  logic signed [15:0] zt_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      busy_q    <= active_d;
      eff_vld_q <= eff_vld;
      eff_q     <= eff_vld ? eff : 16'sd0;
      done_q    <= done;
      zt_out_q  <= zt_d;
    end
  end

  assign result_o.valid             = out_vld_q;
  assign result_o.busy_res          = busy_q;
  assign result_o.effort_valid      = eff_vld_q;
  assign result_o.rotational_effort = eff_q;
  assign result_o.done_res          = done_q;
  assign result_o.zero_torque       = zt_out_q;

endmodule

>>> tb/sv/steering_zero_torque_calibration_test.sv
// self-checking regression of the steering zero-torque calibration sequencer
`timescale 1ns / 1ps

module steering_zero_torque_calibration_test;
  import szt_pkg::*;

  // registers 6 and 7 are unmapped, writes there must not disturb anything
  localparam logic [2:0] SpareRegLo = 3'd6;
  localparam logic [2:0] SpareRegHi = 3'd7;
  // generous stop for a hung handshake
  localparam int unsigned CycleLimit = 300_000;

  // one control tick as the sender sees it
  typedef struct packed {
    logic [31:0]        time_ms;
    logic signed [15:0] wheel_angle;
    logic               start_request;
  } tick_word_t;

  // one result word
  typedef struct packed {
    logic               busy;
    logic               effort_valid;
    logic signed [15:0] effort;
    logic               done;
    logic signed [15:0] zero_torque;
  } calib_word_t;

  // tracks the calibration sequence tick by tick and holds the words still owed
  class calib_sequence_tracker;
    logic [15:0]        timeout_ms;
    logic [14:0]        drive_stop_angle;
    logic [14:0]        return_idle_angle;
    logic [15:0]        return_gain;
    logic [14:0]        full_effort;
    logic signed [15:0] init_zt;

    phase_e             phase;
    bit                 active;
    logic [31:0]        phase_start;
    logic [31:0]        cw_ms;
    logic [31:0]        ccw_ms;
    logic signed [15:0] torque;

    calib_word_t        tick_outcomes[$];
    int unsigned        faults;

    function new();
      timeout_ms        = RstTimeoutMs;
      drive_stop_angle  = RstDriveStop;
      return_idle_angle = RstReturnIdle;
      return_gain       = RstReturnGain;
      full_effort       = RstFullEffort;
      init_zt           = RstInitZt;
      phase             = PH_IDLE;
      active            = 1'b0;
      phase_start       = '0;
      cw_ms             = '0;
      ccw_ms            = '0;
      torque            = RstInitZt;
      faults            = 0;
    endfunction

    function void report(string msg);
      faults++;
      if (faults <= 10) $display("mismatch %0d: %s", faults, msg);
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_TIMEOUT_MS:  timeout_ms        = data[15:0];
        REG_DRIVE_STOP:  drive_stop_angle  = data[14:0];
        REG_RETURN_IDLE: return_idle_angle = data[14:0];
        REG_RETURN_GAIN: return_gain       = data[15:0];
        REG_FULL_EFFORT: full_effort       = data[14:0];
        REG_INIT_ZT: begin
          init_zt = data[15:0];
          torque  = data[15:0];
        end
        default: ;
      endcase
    endfunction

    function void check_reg(logic [2:0] idx, logic [31:0] data);
      logic [31:0] want;
      logic [31:0] mask;
      case (idx)
        REG_TIMEOUT_MS:  begin want = 32'(timeout_ms);        mask = 32'h0000_FFFF; end
        REG_DRIVE_STOP:  begin want = 32'(drive_stop_angle);  mask = 32'h0000_7FFF; end
        REG_RETURN_IDLE: begin want = 32'(return_idle_angle); mask = 32'h0000_7FFF; end
        REG_RETURN_GAIN: begin want = 32'(return_gain);       mask = 32'h0000_FFFF; end
        REG_FULL_EFFORT: begin want = 32'(full_effort);       mask = 32'h0000_7FFF; end
        REG_INIT_ZT:     begin want = 32'(init_zt);           mask = 32'h0000_FFFF; end
        default: return;
      endcase
      if ((data & mask) !== (want & mask))
        report($sformatf("register %0d: expected %h, got %h", idx, want & mask, data & mask));
    endfunction

    // proportional return effort, floor of the scaled product, saturated
    function logic signed [15:0] pull_back(logic signed [15:0] angle);
      longint p;
      p = -(longint'(angle) * longint'(return_gain));
      p = p >>> 13;
      if (p > longint'(EffortMax)) p = longint'(EffortMax);
      else if (p < longint'(EffortMin)) p = longint'(EffortMin);
      return 16'(p);
    endfunction

    function void take_tick(tick_word_t t);
      logic [31:0]        el;
      int                 mag;
      bit                 fired;
      bit                 done;
      logic signed [15:0] effort;
      longint             d;
      longint             c;
      calib_word_t        w;
      mag    = ($signed(t.wheel_angle) < 0) ? -int'($signed(t.wheel_angle))
                                            : int'($signed(t.wheel_angle));
      fired  = 1'b0;
      done   = 1'b0;
      effort = '0;
      if (!active && t.start_request) active = 1'b1;
      if (active) begin
        if (phase == PH_IDLE) begin
          phase_start = t.time_ms;
          cw_ms       = '0;
          ccw_ms      = '0;
          phase       = PH_CCW_FIRST;
        end
        if (phase == PH_CCW_FIRST) begin
          el     = t.time_ms - phase_start;
          effort = -$signed({1'b0, full_effort});
          fired  = 1'b1;
          if (mag > int'(drive_stop_angle) || el > timeout_ms) begin
            ccw_ms      = el;
            phase_start = t.time_ms;
            phase       = PH_RETURN_A;
          end
        end
        if (phase == PH_RETURN_A || phase == PH_RETURN_B) begin
          el    = t.time_ms - phase_start;
          fired = 1'b1;
          if (mag < int'(return_idle_angle) || el > timeout_ms) begin
            effort = '0;
            if (el > timeout_ms) begin
              phase_start = t.time_ms;
              phase       = (phase == PH_RETURN_A) ? PH_CW : PH_CCW_LAST;
            end
          end else begin
            effort = pull_back($signed(t.wheel_angle));
          end
        end
        if (phase == PH_CW) begin
          el     = t.time_ms - phase_start;
          effort = $signed({1'b0, full_effort});
          fired  = 1'b1;
          if (mag > int'(drive_stop_angle) || el > timeout_ms) begin
            cw_ms       = el;
            phase_start = t.time_ms;
            phase       = PH_RETURN_B;
            // second return runs at once with nothing elapsed, so only the angle test counts
            effort = (mag < int'(return_idle_angle)) ? 16'sd0
                                                     : pull_back($signed(t.wheel_angle));
          end
        end
        if (phase == PH_CCW_LAST) begin
          el     = t.time_ms - phase_start;
          effort = -$signed({1'b0, full_effort});
          fired  = 1'b1;
          if (mag > int'(drive_stop_angle) || el > timeout_ms) begin
            ccw_ms      = el;
            phase_start = t.time_ms;
            phase       = PH_ADJUST;
          end
        end
        if (phase == PH_ADJUST) begin
          // correction rounds half away from zero
          d = longint'(cw_ms) - longint'(ccw_ms);
          c = (((d < 0) ? -d : d) + 5) / 10;
          if (d < 0) c = -c;
          if (c == 0) begin
            phase  = PH_IDLE;
            active = 1'b0;
            done   = 1'b1;
          end else begin
            c = longint'(torque) + c;
            if (c > longint'(ZtMax)) c = longint'(ZtMax);
            else if (c < longint'(ZtMin)) c = longint'(ZtMin);
            torque = 16'(c);
            phase  = PH_RETURN_A;
          end
        end
      end
      w.busy         = active;
      w.effort_valid = fired;
      w.effort       = fired ? effort : 16'sd0;
      w.done         = done;
      w.zero_torque  = torque;
      tick_outcomes.push_back(w);
    endfunction

    function void check_word(calib_word_t got);
      calib_word_t want;
      if (tick_outcomes.size() == 0) begin
        report($sformatf("result word with nothing pending: %h", got));
        return;
      end
      want = tick_outcomes.pop_front();
      if (got.busy !== want.busy)
        report($sformatf("busy_res: expected %0b, got %0b", want.busy, got.busy));
      if (got.effort_valid !== want.effort_valid)
        report($sformatf("effort_valid: expected %0b, got %0b",
                         want.effort_valid, got.effort_valid));
      if (got.effort !== want.effort)
        report($sformatf("rotational_effort: expected %0d, got %0d",
                         $signed(want.effort), $signed(got.effort)));
      if (got.done !== want.done)
        report($sformatf("done_res: expected %0b, got %0b", want.done, got.done));
      if (got.zero_torque !== want.zero_torque)
        report($sformatf("zero_torque: expected %0d, got %0d",
                         $signed(want.zero_torque), $signed(got.zero_torque)));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  szt_tick_if   tick_bus ();
  szt_result_if result_bus ();

  steering_zero_torque_calibration u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick_bus),
    .result_o (result_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  calib_sequence_tracker tracker;

  // stimulus state: running timestamp and the drive length aimed at in this run
  logic [31:0] now_ms;
  int unsigned drive_target;
  // when set, neither side idles
  bit          no_gaps;
  int unsigned ready_hold;
  int unsigned cycle_count;

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // signed angle of a given magnitude, -32768 for the one magnitude only reachable negative
  function automatic logic signed [15:0] to_angle(int unsigned mag);
    if (mag >= 32768) return 16'sh8000;
    return $urandom_range(0, 1) ? -16'(mag) : 16'(mag);
  endfunction

  // next tick, shaped by where the sequence stands so that runs get through all phases
  function automatic tick_word_t next_tick();
    tick_word_t  t;
    int unsigned r;
    int unsigned span;
    int unsigned lim;
    int unsigned mag;
    int unsigned tmo;
    logic [31:0] el;
    tmo  = int'(tracker.timeout_ms);
    span = tmo / 4 + 1;
    lim  = int'(tracker.drive_stop_angle);
    r    = $urandom_range(0, 99);
    // time: mostly small steps, sometimes wild jumps or the timeout boundary
    if (r < 2) now_ms = $urandom();
    else if (r < 5) now_ms = tracker.phase_start + 32'(tracker.timeout_ms);
    else if (r < 8) now_ms = tracker.phase_start + 32'(tracker.timeout_ms) + 32'd1;
    else if (r >= 12) now_ms = now_ms + $urandom_range(1, span);
    el              = now_ms - tracker.phase_start;
    t.time_ms       = now_ms;
    t.start_request = 1'b0;
    r               = $urandom_range(0, 99);
    if (r < 12) begin
      // noise
      t.wheel_angle   = 16'($urandom());
      t.start_request = 1'($urandom_range(0, 1));
    end else if (!tracker.active) begin
      t.wheel_angle   = to_angle($urandom_range(0, lim));
      t.start_request = 1'($urandom_range(0, 1));
      if (t.start_request) begin
        // same target for both timed drives tends to a zero correction
        drive_target = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2 * tmo + 2)
                                                   : $urandom_range(0, tmo);
      end
    end else begin
      if (tracker.phase inside {PH_CCW_FIRST, PH_CW, PH_CCW_LAST}) begin
        if (el >= 32'(drive_target)) mag = $urandom_range(lim + 1, 32768);
        else if (r < 20) mag = lim;
        else mag = $urandom_range(0, lim);
      end else begin
        // return phases: around the small-angle boundary, full range, or moderate
        if (r < 20) mag = int'(tracker.return_idle_angle);
        else if (r < 28) mag = (tracker.return_idle_angle > 0)
                               ? int'(tracker.return_idle_angle) - 1 : 0;
        else if (r < 45) mag = $urandom_range(0, 32768);
        else mag = $urandom_range(0, (lim + 200 > 32768) ? 32768 : lim + 200);
      end
      t.wheel_angle   = to_angle(mag);
      // a start during a run must be ignored
      t.start_request = ($urandom_range(0, 3) == 0);
    end
    return t;
  endfunction

  // present one word, hold it until taken; returns at the falling edge after acceptance
  task automatic send_tick(input tick_word_t t);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      tick_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tick_bus.valid         <= 1'b1;
    tick_bus.time_ms       <= t.time_ms;
    tick_bus.wheel_angle   <= t.wheel_angle;
    tick_bus.start_request <= t.start_request;
    @(posedge clk_i);
    while (!tick_bus.ready) @(posedge clk_i);
    tracker.take_tick(t);
    @(negedge clk_i);
  endtask

  // sender holds off until every pending word has come back
  task automatic wait_drained();
    tick_bus.valid <= 1'b0;
    while (tracker.tick_outcomes.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.write_reg(idx, data);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_read(input logic [2:0] idx);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.check_reg(idx, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_all_regs();
    for (int i = 0; i <= int'(REG_INIT_ZT); i++) reg_read(3'(i));
  endtask

  // full register set, written only once nothing is in flight
  task automatic apply_setting(input cfg_t c);
    wait_drained();
    // two-stage pipe, let it settle
    repeat (4) @(negedge clk_i);
    reg_write(REG_TIMEOUT_MS, {16'd0, c.timeout_ms});
    reg_write(REG_DRIVE_STOP, {17'd0, c.drive_stop_angle});
    reg_write(REG_RETURN_IDLE, {17'd0, c.return_idle_angle});
    reg_write(REG_RETURN_GAIN, {16'd0, c.return_gain});
    reg_write(REG_FULL_EFFORT, {17'd0, c.full_effort});
    reg_write(REG_INIT_ZT, {{16{c.initial_zero_torque[15]}}, c.initial_zero_torque});
    // unmapped writes, then read back that nothing moved
    reg_write(SpareRegLo, $urandom());
    reg_write(SpareRegHi, $urandom());
    check_all_regs();
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned hold_at;
    hold_at = $urandom_range(0, count - 1);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == hold_at) wait_drained();
      send_tick(next_tick());
    end
  endtask

  // result side stalls at random, one assignment per falling edge
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      result_bus.ready <= 1'b0;
      ready_hold = ready_hold - 1;
    end else begin
      result_bus.ready <= 1'b1;
      ready_hold = pick_gap();
    end
  end

  // every accepted result is checked at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      tracker.check_word(calib_word_t'{result_bus.busy_res, result_bus.effort_valid,
                                       result_bus.rotational_effort, result_bus.done_res,
                                       result_bus.zero_torque});
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("steering_zero_torque_calibration regression: fail");
      $finish;
    end
  end

  initial begin
    cfg_t settings [6];
    tracker                = new();
    rst_ni                 = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    tick_bus.valid         = 1'b0;
    tick_bus.time_ms       = '0;
    tick_bus.wheel_angle   = '0;
    tick_bus.start_request = 1'b0;
    result_bus.ready       = 1'b0;
    ready_hold             = 0;
    cycle_count            = 0;
    no_gaps                = 1'b0;
    now_ms                 = '0;
    drive_target           = 0;

    // typical scaled down, both extremes, offset near both rails, one random
    settings[0] = cfg_t'{16'd30, 15'd1065, 15'd0, 16'd2000, 15'd100, -16'sd30};
    settings[1] = cfg_t'{16'd1, 15'd0, 15'd0, 16'd0, 15'd0, 16'sh8000};
    settings[2] = cfg_t'{16'hFFFF, 15'h7FFF, 15'h7FFF, 16'hFFFF, 15'h7FFF, 16'sh7FFF};
    settings[3] = cfg_t'{16'd12, 15'd200, 15'd300, 16'hFFFF, 15'h7FFF, 16'sd32760};
    settings[4].timeout_ms          = 16'($urandom_range(1, 200));
    settings[4].drive_stop_angle    = 15'($urandom());
    settings[4].return_idle_angle   = 15'($urandom_range(0, 2000));
    settings[4].return_gain         = 16'($urandom());
    settings[4].full_effort         = 15'($urandom());
    settings[4].initial_zero_torque = 16'($urandom());
    settings[5] = cfg_t'{16'd50, 15'd1065, 15'd0, 16'd2000, 15'd100, -16'sd32760};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // defaults after reset
    check_all_regs();

    // directed walk at reset settings: one complete run ending in done, then a run
    // across the timestamp wrap whose correction moves the offset
    send_tick(tick_word_t'{32'd100, 16'sd0, 1'b0});           // idle, no effort
    send_tick(tick_word_t'{32'd0, 16'sh7FFF, 1'b0});          // idle, extreme angle
    send_tick(tick_word_t'{32'd200, 16'sd0, 1'b1});           // start, first drive at once
    send_tick(tick_word_t'{32'd300, 16'sd500, 1'b1});         // start while running ignored
    send_tick(tick_word_t'{32'd400, 16'sh8000, 1'b0});        // large angle, return same tick
    send_tick(tick_word_t'{32'd1000, 16'sh7FFF, 1'b0});       // proportional return
    send_tick(tick_word_t'{32'd5400, 16'sd1, 1'b0});          // elapsed equals timeout
    send_tick(tick_word_t'{32'd5401, -16'sd1, 1'b0});         // timeout, clockwise same tick
    send_tick(tick_word_t'{32'd6101, 16'sd1066, 1'b0});       // clockwise timed, second return
    send_tick(tick_word_t'{32'd6200, 16'sd1065, 1'b0});       // angle at threshold
    send_tick(tick_word_t'{32'd11201, 16'sd0, 1'b0});         // last counter-clockwise drive
    send_tick(tick_word_t'{32'd11900, -16'sd1066, 1'b0});     // correction zero, done
    send_tick(tick_word_t'{32'hFFFF_FF00, -16'sd200, 1'b1});  // new run near the wrap
    send_tick(tick_word_t'{32'hFFFF_FFFF, 16'sd1066, 1'b1});
    send_tick(tick_word_t'{32'h0000_1400, 16'sd0, 1'b0});     // elapsed across the wrap
    send_tick(tick_word_t'{32'h0000_17E8, -16'sd1066, 1'b0});
    send_tick(tick_word_t'{32'd11121, 16'sd0, 1'b0});
    send_tick(tick_word_t'{32'd11122, 16'sh7FFF, 1'b0});      // nonzero correction, repeat
    send_tick(tick_word_t'{32'd11123, -16'sd5, 1'b0});
    send_tick(tick_word_t'{32'd16123, 16'sd0, 1'b0});
    now_ms       = 32'd16123;
    drive_target = 2500;
    run_random(25);

    foreach (settings[k]) begin
      // second setting runs with no idling at all
      no_gaps = (k == 1) || ($urandom_range(0, 4) == 0);
      apply_setting(settings[k]);
      now_ms = $urandom_range(0, 1)
             ? 32'hFFFF_FFFF - $urandom_range(0, 4 * int'(settings[k].timeout_ms))
             : $urandom();
      run_random(70);
    end

    wait_drained();
    repeat (6) @(posedge clk_i);
    if (tracker.faults == 0 && tracker.tick_outcomes.size() == 0) begin
      $display("steering_zero_torque_calibration regression: pass");
    end else begin
      $display("steering_zero_torque_calibration regression: fail");
    end
    $finish;
  end

endmodule

>>> steering_zero_torque_calibration.f
hw/rtl/szt_pkg.sv
hw/rtl/szt_if.sv
hw/rtl/szt_apb_regs.sv
hw/rtl/steering_zero_torque_calibration.sv
tb/sv/steering_zero_torque_calibration_test.sv
